### hdl/ofd_pkg.sv
// Shared types and constants for the observation frame deframer.
// Word layouts on both queue ports, the queue entry between front and back,
// status codes and field ids. No dependencies.
package ofd_pkg;

    localparam int unsigned MAX_AXES   = 64;
    localparam int unsigned HDR_BYTES  = 56;
    localparam int unsigned AXIS_BYTES = 24;
    localparam int unsigned Q_DEPTH    = 4;
    localparam int unsigned Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] MAGIC_FIRST_RST  = 8'd69;
    localparam logic [7:0] MAGIC_SECOND_RST = 8'd79;
    localparam logic [7:0] VERSION_RST      = 8'd1;
    localparam logic [7:0] KIND_RST         = 8'd1;

    typedef enum logic [1:0] {
        REG_MAGIC_FIRST  = 2'd0,
        REG_MAGIC_SECOND = 2'd1,
        REG_VERSION      = 2'd2,
        REG_KIND         = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_MAGIC   = 3'd1,
        ST_BAD_VERSION = 3'd2,
        ST_BAD_KIND    = 3'd3,
        ST_TOO_MANY    = 3'd4,
        ST_LEN_MISMATCH = 3'd5,
        ST_TRUNCATED   = 3'd6
    } status_t;

    typedef enum logic {
        PH_RECEIVING = 1'b0,
        PH_IGNORING  = 1'b1
    } phase_t;

    localparam logic [4:0] FID_VERSION     = 5'd0;
    localparam logic [4:0] FID_KIND        = 5'd1;
    localparam logic [4:0] FID_FRAME_LEN   = 5'd2;
    localparam logic [4:0] FID_AXIS_COUNT  = 5'd3;
    localparam logic [4:0] FID_FLAGS       = 5'd4;
    localparam logic [4:0] FID_WKC         = 5'd5;
    localparam logic [4:0] FID_PUBLISH     = 5'd6;
    localparam logic [4:0] FID_CYCLE       = 5'd7;
    localparam logic [4:0] FID_MONO_NS     = 5'd8;
    localparam logic [4:0] FID_DEADLINE_NS = 5'd9;
    localparam logic [4:0] FID_INTERVAL_NS = 5'd10;
    localparam logic [4:0] FID_ACT_POS     = 5'd11;
    localparam logic [4:0] FID_TGT_POS     = 5'd12;
    localparam logic [4:0] FID_ACT_VEL     = 5'd13;
    localparam logic [4:0] FID_ACT_TORQUE  = 5'd14;
    localparam logic [4:0] FID_STATUS_WORD = 5'd15;
    localparam logic [4:0] FID_CTRL_WORD   = 5'd16;
    localparam logic [4:0] FID_AXIS_FLAGS  = 5'd17;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } byte_word_t;

    typedef struct packed {
        logic        is_status;
        logic [4:0]  field_id;
        logic [5:0]  axis_num;
        logic [63:0] field_value;
        logic [2:0]  status_code;
        logic        last;
    } result_word_t;

    typedef struct packed {
        logic        has_field;
        logic [4:0]  field_id;
        logic [5:0]  axis_num;
        logic [63:0] field_value;
        logic        has_status;
        status_t     status_code;
    } event_t;

endpackage

### hdl/ofd_front.sv
// Front part of the deframer: configuration registers, byte tracking and checks.
// Turns each accepted byte into at most one event for the back queue.
// Depends on ofd_pkg.
module ofd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  ofd_pkg::byte_word_t byte_word,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [7:0]         wr_data,
    output logic               ev_valid,
    output ofd_pkg::event_t    ev
);
    import ofd_pkg::*;

    logic [7:0]  magic_first_reg, magic_second_reg, version_reg, kind_reg;
    phase_t      phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] len_reg, len_next;
    logic [4:0]  within_reg, within_next;
    logic [5:0]  axis_reg, axis_next;
    logic [63:0] acc_reg, acc_next;

    logic [7:0]  b;
    logic        fin;
    logic [15:0] axes;
    logic [21:0] len_calc;
    logic        frame_done;
    logic        fail;
    status_t     fail_code;
    logic        have;
    logic [4:0]  fid;
    logic [63:0] fval;
    logic        axis_field;
    logic [63:0] val2, val4;

    assign b    = byte_word.data_byte;
    assign fin  = byte_word.buffer_end;
    assign axes = acc_next[63:48];
    assign val2 = {48'd0, acc_next[63:48]};
    assign val4 = {32'd0, acc_next[63:32]};
    assign len_calc = 22'(HDR_BYTES) + {2'd0, axes, 4'd0} + {3'd0, axes, 3'd0};
    assign frame_done = (pos_reg >= 16'(HDR_BYTES - 1))
                        && ({1'b0, pos_reg} + 17'd1 == {1'b0, len_reg});

    always_comb
    begin
        acc_next   = {b, acc_reg[63:8]};
        fail       = 1'b0;
        fail_code  = ST_OK;
        have       = 1'b0;
        fid        = FID_VERSION;
        fval       = 64'd0;
        axis_field = 1'b0;
        if (pos_reg == 16'd0) begin
            if (b != magic_first_reg) begin
                fail = 1'b1; fail_code = ST_BAD_MAGIC;
            end
        end else if (pos_reg == 16'd1) begin
            if (b != magic_second_reg) begin
                fail = 1'b1; fail_code = ST_BAD_MAGIC;
            end
        end else if (pos_reg == 16'd2) begin
            if (b != version_reg) begin
                fail = 1'b1; fail_code = ST_BAD_VERSION;
            end else begin
                have = 1'b1; fid = FID_VERSION; fval = {56'd0, b};
            end
        end else if (pos_reg == 16'd3) begin
            if (b != kind_reg) begin
                fail = 1'b1; fail_code = ST_BAD_KIND;
            end else begin
                have = 1'b1; fid = FID_KIND; fval = {56'd0, b};
            end
        end else if (pos_reg == 16'd5) begin
            have = 1'b1; fid = FID_FRAME_LEN; fval = val2;
        end else if (pos_reg == 16'd7) begin
            if ({1'b0, axes} > 17'(MAX_AXES)) begin
                fail = 1'b1; fail_code = ST_TOO_MANY;
            end else if ({6'd0, len_reg} != len_calc) begin
                fail = 1'b1; fail_code = ST_LEN_MISMATCH;
            end else begin
                have = 1'b1; fid = FID_AXIS_COUNT; fval = val2;
            end
        end else if (pos_reg < 16'(HDR_BYTES)) begin
            case (pos_reg)
                16'd11: begin have = 1'b1; fid = FID_FLAGS;       fval = val4;     end
                16'd15: begin have = 1'b1; fid = FID_WKC;         fval = val4;     end
                16'd23: begin have = 1'b1; fid = FID_PUBLISH;     fval = acc_next; end
                16'd31: begin have = 1'b1; fid = FID_CYCLE;       fval = acc_next; end
                16'd39: begin have = 1'b1; fid = FID_MONO_NS;     fval = acc_next; end
                16'd47: begin have = 1'b1; fid = FID_DEADLINE_NS; fval = acc_next; end
                16'd55: begin have = 1'b1; fid = FID_INTERVAL_NS; fval = acc_next; end
                default: have = 1'b0;
            endcase
        end else begin
            axis_field = 1'b1;
            case (within_reg)
                5'd3:  begin have = 1'b1; fid = FID_ACT_POS;     fval = val4; end
                5'd7:  begin have = 1'b1; fid = FID_TGT_POS;     fval = val4; end
                5'd11: begin have = 1'b1; fid = FID_ACT_VEL;     fval = val4; end
                5'd15: begin have = 1'b1; fid = FID_ACT_TORQUE;  fval = val4; end
                5'd17: begin have = 1'b1; fid = FID_STATUS_WORD; fval = val2; end
                5'd19: begin have = 1'b1; fid = FID_CTRL_WORD;   fval = val2; end
                5'd23: begin have = 1'b1; fid = FID_AXIS_FLAGS;  fval = val4; end
                default: have = 1'b0;
            endcase
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_RECEIVING:
                if (accept && !fin && (fail || frame_done))
                    phase_next = PH_IGNORING;
            PH_IGNORING:
                if (accept && fin)
                    phase_next = PH_RECEIVING;
            default: phase_next = PH_RECEIVING;
        endcase
    end

    // event and counters
    always_comb
    begin
        ev_valid       = 1'b0;
        ev.has_field   = 1'b0;
        ev.field_id    = fid;
        ev.axis_num    = axis_field ? axis_reg : 6'd0;
        ev.field_value = fval;
        ev.has_status  = 1'b0;
        ev.status_code = ST_OK;
        pos_next       = pos_reg;
        len_next       = len_reg;
        within_next    = within_reg;
        axis_next      = axis_reg;
        unique case (phase_reg)
            PH_RECEIVING:
            begin
                if (fail) begin
                    ev.has_status  = 1'b1;
                    ev.status_code = fail_code;
                end else begin
                    ev.has_field = have;
                    if (pos_reg == 16'd5)
                        len_next = axes;
                    if (frame_done) begin
                        ev.has_status  = 1'b1;
                        ev.status_code = ST_OK;
                    end else if (fin) begin
                        ev.has_status  = 1'b1;
                        ev.status_code = ST_TRUNCATED;
                    end else begin
                        pos_next = pos_reg + 16'd1;
                        if (pos_reg >= 16'(HDR_BYTES)) begin
                            if (within_reg == 5'(AXIS_BYTES - 1)) begin
                                within_next = 5'd0;
                                axis_next   = axis_reg + 6'd1;
                            end else begin
                                within_next = within_reg + 5'd1;
                            end
                        end
                    end
                end
                ev_valid = ev.has_field || ev.has_status;
                if (fin && (fail || frame_done || ev.has_status)) begin
                    pos_next    = 16'd0;
                    len_next    = 16'd0;
                    within_next = 5'd0;
                    axis_next   = 6'd0;
                end
            end
            PH_IGNORING:
            begin
                if (fin) begin
                    pos_next    = 16'd0;
                    len_next    = 16'd0;
                    within_next = 5'd0;
                    axis_next   = 6'd0;
                end
            end
            default: ev_valid = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            magic_first_reg  <= MAGIC_FIRST_RST;
            magic_second_reg <= MAGIC_SECOND_RST;
            version_reg      <= VERSION_RST;
            kind_reg         <= KIND_RST;
        end else if (wr_en) begin
            unique case (reg_index_t'(wr_index))
                REG_MAGIC_FIRST:  magic_first_reg  <= wr_data;
                REG_MAGIC_SECOND: magic_second_reg <= wr_data;
                REG_VERSION:      version_reg      <= wr_data;
                REG_KIND:         kind_reg         <= wr_data;
                default:          kind_reg         <= kind_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_RECEIVING;
            pos_reg    <= 16'd0;
            len_reg    <= 16'd0;
            within_reg <= 5'd0;
            axis_reg   <= 6'd0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            within_reg <= within_next;
            axis_reg   <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && phase_reg == PH_RECEIVING)
            acc_reg <= acc_next;
    end

endmodule

### hdl/ofd_back.sv
// Back part of the deframer: event queue and result word expansion.
// Each event gives a field word, a status word, or both in that order.
// Depends on ofd_pkg.
module ofd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  ev_push,
    input  ofd_pkg::event_t       ev,
    output logic                  full,
    output logic                  empty,
    input  logic                  pop,
    output ofd_pkg::result_word_t result_word
);
    import ofd_pkg::*;

    event_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                 sub_reg, sub_next;
    event_t               head;
    logic                 show_field;
    logic                 take;
    logic                 deq;

    assign head       = mem[rd_ptr_reg];
    assign full       = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign empty      = (cnt_reg == '0);
    assign show_field = head.has_field && !sub_reg;
    assign take       = pop && !empty;
    assign deq        = take && !(show_field && head.has_status);

    always_comb
    begin
        if (show_field) begin
            result_word.is_status   = 1'b0;
            result_word.field_id    = head.field_id;
            result_word.axis_num    = head.axis_num;
            result_word.field_value = head.field_value;
            result_word.status_code = 3'(ST_OK);
            result_word.last        = 1'b0;
        end else begin
            result_word.is_status   = 1'b1;
            result_word.field_id    = 5'd0;
            result_word.axis_num    = 6'd0;
            result_word.field_value = 64'd0;
            result_word.status_code = head.status_code;
            result_word.last        = 1'b1;
        end
    end

    always_comb
    begin
        sub_next = sub_reg;
        if (take)
            sub_next = !deq;
        cnt_next = cnt_reg;
        if (ev_push && !deq)
            cnt_next = cnt_reg + Q_CNT_W'(1);
        else if (!ev_push && deq)
            cnt_next = cnt_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            sub_reg    <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            sub_reg <= sub_next;
            if (ev_push)
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (deq)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_push)
            mem[wr_ptr_reg] <= ev;
    end

endmodule

### hdl/observation_frame_deframer_core.sv
// Top level of the observation frame deframer: front checker plus back queue.
// Depends on ofd_pkg, ofd_front and ofd_back.
//
//   port group      handshake          word
//   byte in         push / full        byte_word   (data_byte, buffer_end)
//   result out      pop / empty        result_word (field or status)
//   register write  wr_en              wr_index, wr_data
//
// One byte per clock is taken while full is low; each byte is handled in the cycle it enters.
// A frame's last byte yields two result words, each taken by its own pop.
// full rises only when the four-entry event queue is filled by a stalled consumer.
// Reset loads the register defaults and waits for the first byte of a frame.
module observation_frame_deframer_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  ofd_pkg::byte_word_t   byte_word,
    output logic                  empty,
    input  logic                  pop,
    output ofd_pkg::result_word_t result_word,
    input  logic                  wr_en,
    input  logic [1:0]            wr_index,
    input  logic [7:0]            wr_data
);
    import ofd_pkg::*;

    logic   accept;
    logic   ev_valid;
    event_t ev;

    assign accept = push && !full;

    ofd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .byte_word (byte_word),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .ev_valid  (ev_valid),
        .ev        (ev)
    );

    ofd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .ev_push     (accept && ev_valid),
        .ev          (ev),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .result_word (result_word)
    );

endmodule

### bench/observation_frame_deframer_core_test.sv
// Testbench for observation_frame_deframer_core: drives byte words, predicts every field
// and status word, and compares them as they are popped. Needs only ofd_pkg and the core.
module observation_frame_deframer_core_test;
    import ofd_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         push;
    logic         full;
    byte_word_t   byte_word;
    logic         empty;
    logic         pop;
    result_word_t result_word;
    logic         wr_en;
    logic [1:0]   wr_index;
    logic [7:0]   wr_data;

    observation_frame_deframer_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .byte_word  (byte_word),
        .empty      (empty),
        .pop        (pop),
        .result_word(result_word),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data)
    );

    logic [7:0]   cfg_magic_first;
    logic [7:0]   cfg_magic_second;
    logic [7:0]   cfg_version;
    logic [7:0]   cfg_kind;

    logic [15:0]  frame_pos;
    logic [63:0]  shift_acc;
    logic [15:0]  frame_len;
    logic [15:0]  frame_axes;
    phase_t       frame_phase;

    result_word_t pending_results[$];
    logic [7:0]   frame_buf[$];
    int unsigned  mismatches;
    int unsigned  bytes_sent;
    int unsigned  hold_off_cycles;
    bit           tx_fast;
    bit           force_back_to_back;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic void restart_frame();
        frame_pos   = '0;
        shift_acc   = '0;
        frame_len   = '0;
        frame_axes  = '0;
        frame_phase = PH_RECEIVING;
    endfunction

    function automatic void expect_field(logic [4:0] id, logic [5:0] ax, logic [63:0] value);
        result_word_t r;
        r             = '0;
        r.field_id    = id;
        r.axis_num    = ax;
        r.field_value = value;
        pending_results.push_back(r);
    endfunction

    function automatic void expect_status(status_t code);
        result_word_t r;
        r             = '0;
        r.is_status   = 1'b1;
        r.status_code = code;
        r.last        = 1'b1;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_byte(byte_word_t w);
        int unsigned p;
        int unsigned off;
        int unsigned nbytes;
        status_t     fail;
        bit          have;
        logic [4:0]  id;
        logic [5:0]  ax;
        logic [63:0] value;
        if (frame_phase != PH_RECEIVING)
        begin
            if (w.buffer_end)
                restart_frame();
            return;
        end
        shift_acc = {w.data_byte, shift_acc[63:8]};
        p      = 32'(frame_pos);
        fail   = ST_OK;
        have   = 1'b0;
        id     = '0;
        ax     = '0;
        value  = '0;
        nbytes = 0;
        if (p == 0)
        begin
            if (w.data_byte != cfg_magic_first)
                fail = ST_BAD_MAGIC;
        end
        else if (p == 1)
        begin
            if (w.data_byte != cfg_magic_second)
                fail = ST_BAD_MAGIC;
        end
        else if (p == 2)
        begin
            if (w.data_byte != cfg_version)
                fail = ST_BAD_VERSION;
            else
            begin
                have  = 1'b1;
                id    = FID_VERSION;
                value = {56'd0, w.data_byte};
            end
        end
        else if (p == 3)
        begin
            if (w.data_byte != cfg_kind)
                fail = ST_BAD_KIND;
            else
            begin
                have  = 1'b1;
                id    = FID_KIND;
                value = {56'd0, w.data_byte};
            end
        end
        else if (p == 5)
        begin
            frame_len = shift_acc[63:48];
            have      = 1'b1;
            id        = FID_FRAME_LEN;
            value     = {48'd0, frame_len};
        end
        else if (p == 7)
        begin
            frame_axes = shift_acc[63:48];
            if (frame_axes > MAX_AXES)
                fail = ST_TOO_MANY;
            else if (frame_len != HDR_BYTES + AXIS_BYTES * frame_axes)
                fail = ST_LEN_MISMATCH;
            else
            begin
                have  = 1'b1;
                id    = FID_AXIS_COUNT;
                value = {48'd0, frame_axes};
            end
        end
        else if (p < HDR_BYTES)
        begin
            case (p)
                11: begin id = FID_FLAGS;       nbytes = 4; end
                15: begin id = FID_WKC;         nbytes = 4; end
                23: begin id = FID_PUBLISH;     nbytes = 8; end
                31: begin id = FID_CYCLE;       nbytes = 8; end
                39: begin id = FID_MONO_NS;     nbytes = 8; end
                47: begin id = FID_DEADLINE_NS; nbytes = 8; end
                55: begin id = FID_INTERVAL_NS; nbytes = 8; end
                default: nbytes = 0;
            endcase
        end
        else
        begin
            off = (p - HDR_BYTES) / AXIS_BYTES;
            ax  = off[5:0];
            case ((p - HDR_BYTES) % AXIS_BYTES)
                3:  begin id = FID_ACT_POS;     nbytes = 4; end
                7:  begin id = FID_TGT_POS;     nbytes = 4; end
                11: begin id = FID_ACT_VEL;     nbytes = 4; end
                15: begin id = FID_ACT_TORQUE;  nbytes = 4; end
                17: begin id = FID_STATUS_WORD; nbytes = 2; end
                19: begin id = FID_CTRL_WORD;   nbytes = 2; end
                23: begin id = FID_AXIS_FLAGS;  nbytes = 4; end
                default: nbytes = 0;
            endcase
        end
        if (nbytes != 0)
        begin
            have  = 1'b1;
            value = shift_acc >> (64 - 8 * nbytes);
        end
        if (nbytes == 0 && p >= HDR_BYTES)
            ax = '0;

        if (fail != ST_OK)
        begin
            expect_status(fail);
            if (w.buffer_end)
                restart_frame();
            else
                frame_phase = PH_IGNORING;
            return;
        end
        if (have)
            expect_field(id, ax, value);
        if (p >= HDR_BYTES - 1 && p + 1 == frame_len)
        begin
            expect_status(ST_OK);
            if (w.buffer_end)
                restart_frame();
            else
                frame_phase = PH_IGNORING;
        end
        else if (w.buffer_end)
        begin
            expect_status(ST_TRUNCATED);
            restart_frame();
        end
        else
            frame_pos = 16'(p + 1);
    endfunction

    task automatic send_byte(logic [7:0] data, logic at_end);
        int unsigned gap;
        byte_word_t  w;
        gap = (tx_fast || force_back_to_back) ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 31) == 0)
            tx_fast = !tx_fast;
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        w.data_byte  = data;
        w.buffer_end = at_end;
        push      <= 1'b1;
        byte_word <= w;
        @(negedge clk);
        while (full)
            @(negedge clk);
        predict_byte(w);
        @(posedge clk);
        bytes_sent++;
    endtask

    function automatic void build_frame(int unsigned axes, logic [15:0] len_field,
                                        logic [15:0] axes_field);
        frame_buf.delete();
        frame_buf.push_back(cfg_magic_first);
        frame_buf.push_back(cfg_magic_second);
        frame_buf.push_back(cfg_version);
        frame_buf.push_back(cfg_kind);
        frame_buf.push_back(len_field[7:0]);
        frame_buf.push_back(len_field[15:8]);
        frame_buf.push_back(axes_field[7:0]);
        frame_buf.push_back(axes_field[15:8]);
        for (int unsigned i = 8; i < HDR_BYTES + AXIS_BYTES * axes; i++)
            frame_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic send_buffer(int unsigned cut, int unsigned trail);
        for (int unsigned i = 0; i < cut; i++)
            send_byte(frame_buf[i], trail == 0 && i == cut - 1);
        for (int unsigned j = 0; j < trail; j++)
            send_byte(8'($urandom_range(0, 255)), j == trail - 1);
    endtask

    task automatic settle();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [7:0] value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
        case (idx)
            REG_MAGIC_FIRST:  cfg_magic_first  = value;
            REG_MAGIC_SECOND: cfg_magic_second = value;
            REG_VERSION:      cfg_version      = value;
            REG_KIND:         cfg_kind         = value;
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [7:0] m0, logic [7:0] m1, logic [7:0] ver,
                                  logic [7:0] kind);
        settle();
        write_reg(REG_MAGIC_FIRST, m0);
        write_reg(REG_MAGIC_SECOND, m1);
        write_reg(REG_VERSION, ver);
        write_reg(REG_KIND, kind);
        wr_en <= 1'b0;
    endtask

    task automatic test_header_checks();
        build_frame(0, 16'(HDR_BYTES), 16'd0);
        frame_buf[0] = ~cfg_magic_first;
        send_buffer(1, 0);
        build_frame(0, 16'(HDR_BYTES), 16'd0);
        frame_buf[1] ^= 8'h80;
        send_buffer(2, 1);
        build_frame(0, 16'(HDR_BYTES), 16'd0);
        frame_buf[2] = ~cfg_version;
        send_buffer(3, 0);
        build_frame(0, 16'(HDR_BYTES), 16'd0);
        frame_buf[3] ^= 8'h01;
        send_buffer(4, 1);
        build_frame(0, 16'(HDR_BYTES), 16'd0);
        send_buffer(2, 0);
    endtask

    task automatic test_axis_checks();
        build_frame(0, 16'(HDR_BYTES + AXIS_BYTES * (MAX_AXES + 1)), 16'(MAX_AXES + 1));
        send_buffer(8, 0);
        build_frame(1, 16'(HDR_BYTES + AXIS_BYTES + 1), 16'd1);
        send_buffer(8, 0);
    endtask

    task automatic test_queue_backpressure();
        hold_off_cycles    = 300;
        force_back_to_back = 1'b1;
        build_frame(1, 16'(HDR_BYTES + AXIS_BYTES), 16'd1);
        send_buffer(HDR_BYTES + AXIS_BYTES, 0);
        force_back_to_back = 1'b0;
    endtask

    task automatic test_random_buffers(int unsigned budget);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned axes;
        int unsigned full_len;
        int unsigned cut;
        int unsigned trail;
        int unsigned k;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at)
        begin
            pick     = $urandom_range(0, 99);
            axes     = ($urandom_range(0, 24) == 0) ? MAX_AXES : $urandom_range(0, 3);
            full_len = HDR_BYTES + AXIS_BYTES * axes;
            build_frame(axes, full_len[15:0], axes[15:0]);
            cut   = frame_buf.size();
            trail = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
            if (axes == MAX_AXES)
                cut = $urandom_range(HDR_BYTES + 8, HDR_BYTES + 3 * AXIS_BYTES);
            if (pick < 70)
            begin
                if ($urandom_range(0, 6) == 0)
                    cut = $urandom_range(1, cut - 1);
            end
            else if (pick < 85)
            begin
                k = $urandom_range(0, 7);
                frame_buf[k] ^= 8'h01 << $urandom_range(0, 7);
                if ($urandom_range(0, 3) == 0)
                    frame_buf[k] = 8'($urandom_range(0, 255));
            end
            else
            begin
                cut   = 0;
                trail = $urandom_range(1, 12);
            end
            send_buffer(cut, trail);
        end
    endtask

    task automatic compare_field(string what, logic [63:0] want_v, logic [63:0] got_v);
        if (want_v !== got_v)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want_v, got_v);
        end
    endtask

    initial
    begin
        result_word_t got;
        result_word_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n === 1'b1 && pop === 1'b1 && empty === 1'b0)
            begin
                got = result_word;
                @(posedge clk);
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: word with none expected, actual %h", $time, got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("is_status", 64'(want.is_status), 64'(got.is_status));
                    compare_field("field_id", 64'(want.field_id), 64'(got.field_id));
                    compare_field("axis_num", 64'(want.axis_num), 64'(got.axis_num));
                    compare_field("field_value", want.field_value, got.field_value);
                    compare_field("status_code", 64'(want.status_code),
                                  64'(got.status_code));
                    compare_field("last", 64'(want.last), 64'(got.last));
                end
            end
        end
    end

    initial
    begin
        int unsigned gap;
        bit          rx_fast;
        rx_fast = 1'b0;
        pop <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            gap = rx_fast ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 31) == 0)
                rx_fast = !rx_fast;
            if (hold_off_cycles != 0)
            begin
                gap             = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (gap != 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(negedge clk);
            while (empty !== 1'b0)
                @(negedge clk);
            @(posedge clk);
        end
    end

    initial
    begin
        mismatches         = 0;
        bytes_sent         = 0;
        hold_off_cycles    = 0;
        tx_fast            = 1'b0;
        force_back_to_back = 1'b0;
        cfg_magic_first    = MAGIC_FIRST_RST;
        cfg_magic_second   = MAGIC_SECOND_RST;
        cfg_version        = VERSION_RST;
        cfg_kind           = KIND_RST;
        restart_frame();
        rst_n     <= 1'b0;
        push      <= 1'b0;
        byte_word <= '0;
        wr_en     <= 1'b0;
        wr_index  <= REG_MAGIC_FIRST;
        wr_data   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_checks();
        test_axis_checks();
        test_queue_backpressure();
        test_random_buffers(330);
        apply_settings(8'h00, 8'h00, 8'h00, 8'h00);
        test_random_buffers(180);
        apply_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        test_random_buffers(180);
        apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        test_random_buffers(150);
        settle();

        if (mismatches == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
